FILE: design/scfa_pkg.sv
// scfa_pkg: shared types and opcode constants for the constant fold alu
// no dependencies
package scfa_pkg;

    localparam int XLEN = 64;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_AND = 5'd3,
        OP_OR = 5'd4, OP_XOR = 5'd5, OP_SDIV = 5'd6, OP_UDIV = 5'd7,
        OP_SREM = 5'd8, OP_UREM = 5'd9, OP_SHL = 5'd10, OP_SHR = 5'd11,
        OP_SAR = 5'd12, OP_EQ = 5'd13, OP_NE = 5'd14, OP_LT = 5'd15,
        OP_LE = 5'd16, OP_GT = 5'd17, OP_GE = 5'd18, OP_ULT = 5'd19,
        OP_ULE = 5'd20, OP_UGT = 5'd21, OP_UGE = 5'd22
    } op_t;

    typedef struct packed {
        logic [4:0]        func;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
    } req_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               ok;
    } rsp_t;

    // metadata carried beside the divider
    typedef struct packed {
        logic        is_div;
        logic        is_rem;
        logic        neg_q;
        logic        neg_r;
        logic        bad;
        logic [63:0] fast_value;
        logic        fast_ok;
    } meta_t;

endpackage

FILE: design/scfa_mul.sv
// scfa_mul: pipelined 64x64 low-half multiplier built from 32-bit partial products
// depends on scfa_pkg
module scfa_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] product
);
    import scfa_pkg::*;

    logic [63:0] ll_reg, ll_next;
    logic [31:0] lh_reg, lh_next, hl_reg, hl_next;
    logic [63:0] p_reg, p_next;
    logic        v1_reg;

    assign ll_next = 64'(a[31:0]) * 64'(b[31:0]);
    assign lh_next = a[31:0] * b[63:32];
    assign hl_next = a[63:32] * b[31:0];
    assign p_next  = ll_reg + {lh_reg + hl_reg, 32'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ll_reg <= ll_next;
        lh_reg <= lh_next;
        hl_reg <= hl_next;
        if (v1_reg)
        begin
            p_reg <= p_next;
        end
    end

    assign product = p_reg;
endmodule

FILE: design/scfa_div.sv
// scfa_div: fully pipelined restoring divider, one quotient bit per stage
// depends on scfa_pkg
module scfa_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        out_valid,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);
    import scfa_pkg::*;

    localparam int STAGES = XLEN;

    logic [STAGES:1]       v_reg;
    logic [63:0]           q_reg [1:STAGES];
    logic [63:0]           r_reg [1:STAGES];
    logic [63:0]           d_reg [1:STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic        v_in;
        logic [63:0] q_in, r_in, d_in;
        logic [64:0] trial;
        logic [64:0] diff;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign q_in = dividend;
            assign r_in = 64'd0;
            assign d_in = divisor;
        end
        else
        begin : g_next
            assign v_in = v_reg[s];
            assign q_in = q_reg[s];
            assign r_in = r_reg[s];
            assign d_in = d_reg[s];
        end

        assign trial = {r_in, q_in[63]};
        assign diff  = trial - {1'b0, d_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else
            begin
                v_reg[s+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            d_reg[s+1] <= d_in;
            if (!diff[64])
            begin
                r_reg[s+1] <= diff[63:0];
                q_reg[s+1] <= {q_in[62:0], 1'b1};
            end
            else
            begin
                r_reg[s+1] <= trial[63:0];
                q_reg[s+1] <= {q_in[62:0], 1'b0};
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign quotient  = q_reg[STAGES];
    assign remainder = r_reg[STAGES];
endmodule

FILE: design/safe_constant_fold_alu.sv
// safe_constant_fold_alu: 64-bit alu with ok flag, fully pipelined
// depends on scfa_pkg, scfa_mul, scfa_div
//
// channel | ports                 | handshake
// request | start, busy, req      | taken when start && !busy
// result  | done, rsp             | one-cycle strobe, no backpressure
//
// one word enters per cycle; busy is tied low
// every word goes from start to done through the operand registers, the 64-stage divider
// and the output register; all ops take equally long
// reset clears valid bits only; results cannot be stalled
module safe_constant_fold_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  scfa_pkg::req_t      req,
    output logic                done,
    output scfa_pkg::rsp_t      rsp
);
    import scfa_pkg::*;

    localparam int MUL_LAT = 2;

    logic        acc;
    logic [63:0] a, b;
    logic [4:0]  f;
    logic        neg_a, neg_b, sh_ok, div_zero, sovf;
    logic [63:0] mag_a, mag_b, fast_v;
    logic        fast_ok, is_s, is_u;
    logic [5:0]  sh;

    assign busy = 1'b0;
    assign acc  = start && !busy;
    assign a = req.lhs;
    assign b = req.rhs;
    assign f = req.func;

    // stage 0 registers
    logic        v0_reg;
    meta_t       m0_reg, m0_next;
    logic [63:0] da_reg, db_reg, ma_reg, mb_reg;
    logic        is_mul0_reg;

    always_comb
    begin
        neg_a    = a[63];
        neg_b    = b[63];
        sh       = b[5:0];
        sh_ok    = b[63:6] == 58'd0;
        div_zero = b == 64'd0;
        sovf     = (a == 64'h8000_0000_0000_0000) && (b == '1);
        mag_a    = neg_a ? (~a + 64'd1) : a;
        mag_b    = neg_b ? (~b + 64'd1) : b;
        fast_v   = '0;
        fast_ok  = 1'b1;
        is_s     = (f == OP_SDIV) || (f == OP_SREM);
        is_u     = (f == OP_UDIV) || (f == OP_UREM);
        unique case (f)
            OP_ADD:  fast_v = a + b;
            OP_SUB:  fast_v = a - b;
            OP_MUL:  fast_v = '0;
            OP_AND:  fast_v = a & b;
            OP_OR:   fast_v = a | b;
            OP_XOR:  fast_v = a ^ b;
            OP_SDIV, OP_UDIV, OP_SREM, OP_UREM: fast_v = '0;
            OP_SHL:  fast_v = a << sh;
            OP_SHR:  fast_v = a >> sh;
            OP_SAR:  fast_v = $signed(a) >>> sh;
            OP_EQ:   fast_v = 64'(a == b);
            OP_NE:   fast_v = 64'(a != b);
            OP_LT:   fast_v = 64'($signed(a) < $signed(b));
            OP_LE:   fast_v = 64'($signed(a) <= $signed(b));
            OP_GT:   fast_v = 64'($signed(a) > $signed(b));
            OP_GE:   fast_v = 64'($signed(a) >= $signed(b));
            OP_ULT:  fast_v = 64'(a < b);
            OP_ULE:  fast_v = 64'(a <= b);
            OP_UGT:  fast_v = 64'(a > b);
            OP_UGE:  fast_v = 64'(a >= b);
            default: fast_ok = 1'b0;
        endcase
        if ((f == OP_SHL || f == OP_SHR || f == OP_SAR) && !sh_ok)
        begin
            fast_ok = 1'b0;
        end
        m0_next.is_div     = is_s || is_u;
        m0_next.is_rem     = (f == OP_SREM) || (f == OP_UREM);
        m0_next.neg_q      = is_s && (neg_a != neg_b);
        m0_next.neg_r      = is_s && neg_a;
        m0_next.bad        = div_zero || (is_s && sovf);
        m0_next.fast_value = fast_ok ? fast_v : '0;
        m0_next.fast_ok    = fast_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        m0_reg      <= m0_next;
        is_mul0_reg <= f == OP_MUL;
        da_reg      <= is_s ? mag_a : a;
        db_reg      <= is_s ? mag_b : b;
        ma_reg      <= a;
        mb_reg      <= b;
    end

    // multiplier
    logic [63:0] prod;
    scfa_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v0_reg),
        .a        (ma_reg),
        .b        (mb_reg),
        .product  (prod)
    );

    // divider
    logic        dv;
    logic [63:0] quo, rem;
    scfa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .dividend  (da_reg),
        .divisor   (db_reg),
        .out_valid (dv),
        .quotient  (quo),
        .remainder (rem)
    );

    localparam int DLAT = XLEN;

    // side pipeline for metadata and the multiply product
    meta_t       m_sr [DLAT];
    logic        mul_sr [DLAT];
    logic [63:0] p_sr [DLAT - MUL_LAT];

    always_ff @(posedge clk)
    begin
        m_sr[0]   <= m0_reg;
        mul_sr[0] <= is_mul0_reg;
        p_sr[0]   <= prod;
        for (int i = 1; i < DLAT; i++)
        begin
            m_sr[i]   <= m_sr[i-1];
            mul_sr[i] <= mul_sr[i-1];
        end
        for (int i = 1; i < DLAT - MUL_LAT; i++)
        begin
            p_sr[i] <= p_sr[i-1];
        end
    end

    // sign fix and output registers
    meta_t       mt;
    logic [63:0] qv, rv, res_next;
    logic        ok_next;
    rsp_t        rsp_reg;
    logic        done_reg;

    assign mt = m_sr[DLAT-1];

    always_comb
    begin
        qv = mt.neg_q ? (~quo + 64'd1) : quo;
        rv = mt.neg_r ? (~rem + 64'd1) : rem;
        priority if (mt.is_div)
        begin
            ok_next  = !mt.bad;
            res_next = mt.bad ? '0 : (mt.is_rem ? rv : qv);
        end
        else if (mul_sr[DLAT-1])
        begin
            ok_next  = 1'b1;
            res_next = p_sr[DLAT-MUL_LAT-1];
        end
        else
        begin
            ok_next  = mt.fast_ok;
            res_next = mt.fast_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg.value <= res_next;
        rsp_reg.ok    <= ok_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef ASSERT_OFF
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##66 done)
        else $error("result strobe missing");
    a_nores: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc, 66))
        else $error("spurious result strobe");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.ok |-> rsp.value == 64'd0)
        else $error("nonzero value with ok low");
`endif
endmodule
